// ===== hdl/ibp_pkg.sv =====
// shared types and constants of the burst packer
package ibp_pkg;

    // input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // configuration register indexes
    localparam logic CFG_BURST_BYTES = 1'b0;
    localparam logic CFG_DATA_TYPE   = 1'b1;

    // configuration reset values
    localparam logic [13:0] BURST_BYTES_RST = 14'd6144;
    localparam logic [4:0]  DATA_TYPE_RST   = 5'd1;

    // burst framing constants
    localparam logic [15:0] SYNC_A          = 16'hF872;
    localparam logic [15:0] SYNC_B          = 16'h4E1F;
    localparam logic [13:0] HEADER_WORDS    = 14'd8;
    localparam logic [12:0] MAX_BURST_WORDS = 13'd4096;

    // position of each header word and of the padding run in the start sequence
    localparam logic [3:0] POS_SYNC_A  = 4'd4;
    localparam logic [3:0] POS_SYNC_B  = 4'd5;
    localparam logic [3:0] POS_PC      = 4'd6;
    localparam logic [3:0] POS_PD      = 4'd7;
    localparam logic [3:0] POS_PADDING = 4'd8;

    // one accepted input word
    typedef struct packed {
        logic        command;
        logic [12:0] frame_bytes;
        logic [7:0]  data_byte;
    } t_job;

    // burst state carried between words
    typedef struct packed {
        logic        in_frame;
        logic [12:0] bytes_remaining;
        logic [11:0] padding_words;
        logic [7:0]  held_byte;
        logic        byte_pending;
    } t_state;

    // one output word
    typedef struct packed {
        logic [15:0] burst_word;
        logic [12:0] repeat_count;
        logic        burst_end;
        logic        error;
    } t_result;

endpackage

// ===== hdl/iec61937_burst_packer_top.sv =====
// burst packer top level: job register, burst state, output register
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------------
//  input     | i_in_valid / o_in_ready    | i_command, i_frame_bytes, i_data_byte
//  output    | o_out_valid / i_out_ready  | o_burst_word, o_repeat_count,
//            |                            | o_burst_end, o_error
//  config    | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// byte words stream at one word per cycle while the output register has room
// a start word holds the job register while it gives its header words, and the
// padding run when its frame is empty, or a single error word when it is too long;
// a byte that ends a frame with padding gives its data word and then the padding run
// the single output register sets the rate: one result word per cycle while i_out_ready holds
// output stalls hold the job register; words with no result never stall
// synchronous reset clears the job, output valid, burst state and config
module iec61937_burst_packer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [12:0] i_frame_bytes,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_burst_word,
    output logic [12:0] o_repeat_count,
    output logic        o_burst_end,
    output logic        o_error
);
    import ibp_pkg::*;

    logic [13:0] r_burst_bytes;
    logic [4:0]  r_data_type;
    logic        r_job_valid;
    t_job        r_job;
    logic [3:0]  r_idx;
    logic [3:0]  n_idx;
    t_state      r_state;
    logic        r_out_valid;
    t_result     r_out;

    logic [3:0]  w_count;
    t_result     w_result;
    t_state      w_next;
    logic        w_out_free;
    logic        w_fire;
    logic        w_last;
    logic        w_accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_bytes <= BURST_BYTES_RST;
            r_data_type   <= DATA_TYPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BURST_BYTES: r_burst_bytes <= i_cfg_data;
                CFG_DATA_TYPE:   r_data_type   <= i_cfg_data[4:0];
                default:         r_data_type   <= r_data_type;
            endcase
        end
    end

    ibp_decode u_decode (
        .i_job        (r_job),
        .i_state      (r_state),
        .i_index      (r_idx),
        .i_burst_bytes(r_burst_bytes),
        .i_data_type  (r_data_type),
        .o_count      (w_count),
        .o_result     (w_result),
        .o_next       (w_next)
    );

    // job stepping: one result per cycle while the output register has room
    always_comb begin
        w_out_free = !r_out_valid || i_out_ready;
        w_fire     = r_job_valid && ((w_count == 4'd0) || w_out_free);
        w_last     = (w_count == 4'd0) || (r_idx == (w_count - 4'd1));
        o_in_ready = !r_job_valid || (w_fire && w_last);
        w_accept   = i_in_valid && o_in_ready;
        n_idx      = r_idx;
        if (w_accept) begin
            n_idx = 4'd0;
        end else if (w_fire && !w_last) begin
            n_idx = r_idx + 4'd1;
        end
    end

    // job register and burst state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= 4'd0;
            r_state     <= '0;
        end else begin
            r_idx <= n_idx;
            if (w_fire && w_last) begin
                r_state <= w_next;
            end
            if (w_accept) begin
                r_job_valid <= 1'b1;
            end else if (w_fire && w_last) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= '{command: i_command, frame_bytes: i_frame_bytes,
                       data_byte: i_data_byte};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && (w_count != 4'd0)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && (w_count != 4'd0)) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_burst_word   = r_out.burst_word;
    assign o_repeat_count = r_out.repeat_count;
    assign o_burst_end    = r_out.burst_end;
    assign o_error        = r_out.error;

endmodule

// ===== hdl/ibp_decode.sv =====
// result selection and next burst state for the word held in the job register
module ibp_decode (
    input  ibp_pkg::t_job    i_job,
    input  ibp_pkg::t_state  i_state,
    input  logic [3:0]       i_index,
    input  logic [13:0]      i_burst_bytes,
    input  logic [4:0]       i_data_type,
    output logic [3:0]       o_count,
    output ibp_pkg::t_result o_result,
    output ibp_pkg::t_state  o_next
);
    import ibp_pkg::*;

    logic [12:0] w_half;
    logic [12:0] w_bw;
    logic [13:0] w_need;
    logic        w_too_long;
    logic [11:0] w_start_pad;
    logic [12:0] w_rem;
    logic        w_finish;
    t_result     w_pad_res;

    // burst size and room check for a start word
    always_comb begin
        w_half      = i_burst_bytes[13:1];
        w_bw        = (w_half > MAX_BURST_WORDS) ? MAX_BURST_WORDS : w_half;
        w_need      = HEADER_WORDS + ((14'(i_job.frame_bytes) + 14'd1) >> 1);
        w_too_long  = w_need > {1'b0, w_bw};
        w_start_pad = 12'({1'b0, w_bw} - w_need);
        w_rem       = i_state.bytes_remaining - 13'd1;
        w_finish    = (w_rem == 13'd0);
    end

    // result at the current position and the state after the word
    always_comb begin
        o_next    = i_state;
        o_count   = 4'd0;
        o_result  = '{burst_word: 16'h0000, repeat_count: 13'd1,
                      burst_end: 1'b0, error: 1'b0};
        w_pad_res = '{burst_word: 16'h0000, repeat_count: 13'd1,
                      burst_end: 1'b1, error: 1'b0};
        if (i_job.command == CMD_START) begin
            if (w_too_long) begin
                o_count        = 4'd1;
                o_result.error = 1'b1;
            end else begin
                o_next.padding_words   = w_start_pad;
                o_next.bytes_remaining = i_job.frame_bytes;
                o_next.byte_pending    = 1'b0;
                o_next.held_byte       = 8'h00;
                o_next.in_frame        = (i_job.frame_bytes != 13'd0);
                o_count = ((i_job.frame_bytes == 13'd0) && (w_start_pad != 12'd0))
                          ? 4'd9 : 4'd8;
                w_pad_res.repeat_count = {1'b0, w_start_pad};
                unique case (i_index)
                    POS_SYNC_A:  o_result.burst_word = SYNC_A;
                    POS_SYNC_B:  o_result.burst_word = SYNC_B;
                    POS_PC:      o_result.burst_word = {11'd0, i_data_type};
                    POS_PD: begin
                        o_result.burst_word = {i_job.frame_bytes, 3'b000};
                        o_result.burst_end  = (i_job.frame_bytes == 13'd0) &&
                                              (w_start_pad == 12'd0);
                    end
                    POS_PADDING: o_result = w_pad_res;
                    default:     o_result.burst_word = 16'h0000;
                endcase
            end
        end else if (!i_state.in_frame) begin
            // byte outside a frame
            o_count        = 4'd1;
            o_result.error = 1'b1;
        end else begin
            o_next.bytes_remaining = w_rem;
            w_pad_res.repeat_count = {1'b0, i_state.padding_words};
            if (i_state.byte_pending || w_finish) begin
                o_count = (w_finish && (i_state.padding_words != 12'd0)) ? 4'd2 : 4'd1;
                o_next.byte_pending = 1'b0;
                if (w_finish) begin
                    o_next.in_frame = 1'b0;
                end
                if (i_index == 4'd0) begin
                    o_result.burst_word = i_state.byte_pending
                                          ? {i_state.held_byte, i_job.data_byte}
                                          : {i_job.data_byte, 8'h00};
                    o_result.burst_end  = w_finish && (i_state.padding_words == 12'd0);
                end else begin
                    o_result = w_pad_res;
                end
            end else begin
                // first byte of a pair waits for its partner
                o_next.held_byte    = i_job.data_byte;
                o_next.byte_pending = 1'b1;
            end
        end
    end

endmodule

// ===== hdl/ibp_checker.sv =====
// port checks for the burst packer, bound to the top level
module ibp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_burst_word,
    input logic [12:0] o_repeat_count,
    input logic        o_burst_end,
    input logic        o_error
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_burst_word)
            && $stable(o_repeat_count))
        else $error("output word changed while stalled");

    // an error word is a bare zero word that never ends a burst
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_burst_word == 16'h0000
            && o_repeat_count == 13'd1 && !o_burst_end)
        else $error("malformed error word");

    // only the padding run repeats, and it always closes the burst
    a_padding_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_repeat_count != 13'd1 |-> o_burst_word == 16'h0000
            && o_burst_end && !o_error && o_repeat_count != 13'd0)
        else $error("malformed padding run");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind iec61937_burst_packer_top ibp_checker u_ibp_checker (.*);
